// ===== rtl/frgr_pkg.sv =====
// Shared constants, codes and types of the frame geometric remap reader.
`default_nettype none

package frgr_pkg;

	localparam int FRAME_SIDE  = 256;
	localparam int HALF_SIDE   = FRAME_SIDE / 2;
	localparam int COORD_W     = $clog2(FRAME_SIDE);
	localparam int ADDR_W      = 2 * COORD_W;
	localparam int CHAN_W      = 8;
	localparam int PIX_W       = 3 * CHAN_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 3;

	localparam logic [COORD_W-1:0] HALF_C      = COORD_W'(HALF_SIDE);
	localparam logic [COORD_W-1:0] LAST_C      = COORD_W'(FRAME_SIDE - 1);
	localparam logic [COORD_W-1:0] UPPER_C     = COORD_W'(FRAME_SIDE - HALF_SIDE);
	localparam logic [COORD_W:0]   QUAD_SPAN_C = (COORD_W + 1)'(2 * HALF_SIDE);
	localparam logic [COORD_W-1:0] SHRINK_LIM2 = COORD_W'(FRAME_SIDE / 2);
	localparam logic [COORD_W-1:0] SHRINK_LIM3 = COORD_W'(FRAME_SIDE / 3);
	localparam logic [COORD_W-1:0] SHRINK_LIM4 = COORD_W'(FRAME_SIDE / 4);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENLARGE_Q   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_SIDE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_Q0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_Q1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_Q2  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE_Q3  = 3'd7;

	localparam logic [2:0] OP_INVERT  = 3'd0;
	localparam logic [2:0] OP_ENLARGE = 3'd1;
	localparam logic [2:0] OP_SHRINK  = 3'd2;
	localparam logic [2:0] OP_MIRROR  = 3'd3;
	localparam logic [2:0] OP_SHUFFLE = 3'd4;

	localparam logic [1:0] MIR_RIGHT_ONTO_LEFT = 2'd0;
	localparam logic [1:0] MIR_LEFT_ONTO_RIGHT = 2'd1;
	localparam logic [1:0] MIR_UPPER_ONTO_LOWER = 2'd2;
	localparam logic [1:0] MIR_LOWER_ONTO_UPPER = 2'd3;

	localparam logic [2:0] SHRINK_MIN = 3'd2;
	localparam logic [2:0] SHRINK_MID = 3'd3;
	localparam logic [2:0] SHRINK_MAX = 3'd4;
	localparam logic [2:0] SHUF_KEEP  = 3'd0;
	localparam logic [2:0] SHUF_LAST  = 3'd4;

	typedef enum logic [1:0] {
		POST_PASS,
		POST_INVERT,
		POST_WHITE
	} post_t;

	typedef struct packed {
		logic [2:0]      op_mode;
		logic [1:0]      enlarge_quadrant;
		logic [2:0]      shrink_factor;
		logic [1:0]      mirror_side;
		logic [3:0][2:0] shuffle_src;
	} cfg_t;

	typedef struct packed {
		logic               is_write;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   wdata;
		post_t              post;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/frgr_if.sv =====
// Request and response channel interfaces of the frame geometric remap reader.
`default_nettype none

interface frgr_req_if import frgr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] col;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;

	modport source (output valid, command, row, col, red_in, green_in, blue_in, input ready);
	modport sink (input valid, command, row, col, red_in, green_in, blue_in, output ready);
endinterface

interface frgr_rsp_if import frgr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/frgr_front.sv =====
// Front end: accepts words, maps a read's position to a stored address and picks the post step.
`default_nettype none

module frgr_front import frgr_pkg::*; (
	frgr_req_if.sink    req,
	input  cfg_t        cfg,
	input  logic        queue_full,
	output logic        job_valid,
	output job_t        job
);

	logic [COORD_W-1:0] r;
	logic [COORD_W-1:0] c;
	logic [COORD_W-1:0] src_row;
	logic [COORD_W-1:0] src_col;
	logic [COORD_W-1:0] lim;
	logic [COORD_W+2:0] srow_w;
	logic [COORD_W+2:0] scol_w;
	logic [2:0]         fct;
	logic [2:0]         code;
	logic [1:0]         s;
	logic               qr;
	logic               qc;
	post_t              post;

	always_comb begin
		r = req.row;
		c = req.col;
		src_row = r;
		src_col = c;
		post = POST_PASS;
		if (cfg.shrink_factor < SHRINK_MIN) begin
			fct = SHRINK_MIN;
		end else if (cfg.shrink_factor > SHRINK_MAX) begin
			fct = SHRINK_MAX;
		end else begin
			fct = cfg.shrink_factor;
		end
		case (fct)
			SHRINK_MID: begin
				lim = SHRINK_LIM3;
			end
			SHRINK_MAX: begin
				lim = SHRINK_LIM4;
			end
			default: begin
				lim = SHRINK_LIM2;
			end
		endcase
		srow_w = ({3'b000, r} * (COORD_W + 3)'(fct)) + (COORD_W + 3)'(fct) - (COORD_W + 3)'(1);
		scol_w = ({3'b000, c} * (COORD_W + 3)'(fct)) + (COORD_W + 3)'(fct) - (COORD_W + 3)'(1);
		qr = (r >= HALF_C);
		qc = (c >= HALF_C);
		code = cfg.shuffle_src[{qr, qc}];
		s = 2'(code - 3'd1);
		case (cfg.op_mode)
			OP_INVERT: begin
				post = POST_INVERT;
			end
			OP_ENLARGE: begin
				src_row = (cfg.enlarge_quadrant[1] ? HALF_C : '0) + (r >> 1);
				src_col = (cfg.enlarge_quadrant[0] ? HALF_C : '0) + (c >> 1);
			end
			OP_SHRINK: begin
				if (r < lim && c < lim) begin
					src_row = srow_w[COORD_W-1:0];
					src_col = scol_w[COORD_W-1:0];
				end else begin
					post = POST_WHITE;
				end
			end
			OP_MIRROR: begin
				case (cfg.mirror_side)
					MIR_RIGHT_ONTO_LEFT: begin
						if (c < HALF_C) src_col = LAST_C - c;
					end
					MIR_LEFT_ONTO_RIGHT: begin
						if (c >= UPPER_C) src_col = LAST_C - c;
					end
					MIR_UPPER_ONTO_LOWER: begin
						if (r >= UPPER_C) src_row = LAST_C - r;
					end
					default: begin
						if (r < HALF_C) src_row = LAST_C - r;
					end
				endcase
			end
			OP_SHUFFLE: begin
				if ({1'b0, r} < QUAD_SPAN_C && {1'b0, c} < QUAD_SPAN_C &&
						code != SHUF_KEEP && code <= SHUF_LAST) begin
					src_row = (s[1] ? HALF_C : '0) + (r - (qr ? HALF_C : '0));
					src_col = (s[0] ? HALF_C : '0) + (c - (qc ? HALF_C : '0));
				end
			end
			default: begin
				post = POST_PASS;
			end
		endcase
	end

	assign req.ready = !queue_full;
	assign job_valid = req.valid;

	always_comb begin
		job.is_write = (req.command == CMD_WRITE);
		job.row = (req.command == CMD_WRITE) ? r : src_row;
		job.col = (req.command == CMD_WRITE) ? c : src_col;
		job.wdata = {req.red_in, req.green_in, req.blue_in};
		job.post = post;
	end

endmodule

`default_nettype wire

// ===== rtl/frgr_queue.sv =====
// Short first-in first-out queue of jobs between the front and back ends.
`default_nettype none

module frgr_queue import frgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	output logic head_valid,
	output job_t head_data,
	input  logic pop
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W + 1)'(push && !full) - (QPTR_W + 1)'(pop && head_valid);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/frgr_back.sv =====
// Back end: frame memory access, pixel post step and two-word output buffer.
`default_nettype none

module frgr_back import frgr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  job_t        head_data,
	output logic        pop,
	frgr_rsp_if.source  rsp
);

	logic [PIX_W-1:0] frame_mem [FRAME_SIDE * FRAME_SIDE];
	logic [PIX_W-1:0] rdata_s1;
	logic             valid_s1;
	post_t            post_s1;
	logic [PIX_W-1:0] pix;
	logic [PIX_W-1:0] ob_data_q [2];
	logic             ob_wr_q;
	logic             ob_rd_q;
	logic [1:0]       ob_count_q;
	logic             ob_pop;
	logic [2:0]       ob_fill;
	logic             space;
	logic [ADDR_W-1:0] addr;

	assign addr = {head_data.row, head_data.col};
	assign ob_pop = rsp.valid && rsp.ready;
	assign ob_fill = {1'b0, ob_count_q} + {2'b00, valid_s1} - {2'b00, ob_pop};
	assign space = (ob_fill < 3'd2);
	assign pop = head_valid && (head_data.is_write || space);

	always_ff @(posedge clk) begin
		if (pop && head_data.is_write) begin
			frame_mem[addr] <= head_data.wdata;
		end
		rdata_s1 <= frame_mem[addr];
		if (pop) begin
			post_s1 <= head_data.post;
		end
	end

	always_comb begin
		case (post_s1)
			POST_INVERT: begin
				pix = ~rdata_s1;
			end
			POST_WHITE: begin
				pix = '1;
			end
			default: begin
				pix = rdata_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ob_data_q[ob_wr_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ob_wr_q <= 1'b0;
			ob_rd_q <= 1'b0;
			ob_count_q <= '0;
		end else begin
			valid_s1 <= pop && !head_data.is_write;
			if (valid_s1) begin
				ob_wr_q <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			ob_count_q <= ob_count_q + {1'b0, valid_s1} - {1'b0, ob_pop};
		end
	end

	assign rsp.valid = (ob_count_q != '0);
	assign rsp.red_out = ob_data_q[ob_rd_q][PIX_W-1 -: CHAN_W];
	assign rsp.green_out = ob_data_q[ob_rd_q][2*CHAN_W-1 -: CHAN_W];
	assign rsp.blue_out = ob_data_q[ob_rd_q][CHAN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/frame_geometric_remap_reader.sv =====
// Top level of the frame geometric remap reader: configuration registers and the three parts.
//
// The req channel carries one word per pixel access: command selects a write of
// red_in, green_in and blue_in into the stored frame at (row, col), or a read.
// A read returns one word on the rsp channel holding the pixel that the chosen
// transform places at (row, col); a write returns nothing. Words leave in order.
// The configuration port takes cfg_we, cfg_index and cfg_wdata; the user must
// write it only while no access is outstanding, as the block does not enforce it.
// One access is accepted per cycle while the job queue is not full. A read
// passes through the job queue, the registered frame memory read and the output
// buffer before it appears on rsp.
// When the receiver stalls, the two-word output buffer fills, then the four-word
// job queue, and then req.ready falls; a write at the head of the queue still drains.
// Reset clears the configuration to its defaults and empties the queue and the
// buffer at once; the frame contents are undefined until written.
`default_nettype none

module frame_geometric_remap_reader import frgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	frgr_req_if.sink              req,
	frgr_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic queue_full;
	logic head_valid;
	job_t head_data;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_mode <= OP_INVERT;
			cfg_q.enlarge_quadrant <= '0;
			cfg_q.shrink_factor <= SHRINK_MIN;
			cfg_q.mirror_side <= MIR_RIGHT_ONTO_LEFT;
			cfg_q.shuffle_src <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OP_MODE: begin
					cfg_q.op_mode <= cfg_wdata;
				end
				REG_ENLARGE_Q: begin
					cfg_q.enlarge_quadrant <= cfg_wdata[1:0];
				end
				REG_SHRINK: begin
					cfg_q.shrink_factor <= cfg_wdata;
				end
				REG_MIRROR_SIDE: begin
					cfg_q.mirror_side <= cfg_wdata[1:0];
				end
				REG_SHUFFLE_Q0: begin
					cfg_q.shuffle_src[0] <= cfg_wdata;
				end
				REG_SHUFFLE_Q1: begin
					cfg_q.shuffle_src[1] <= cfg_wdata;
				end
				REG_SHUFFLE_Q2: begin
					cfg_q.shuffle_src[2] <= cfg_wdata;
				end
				REG_SHUFFLE_Q3: begin
					cfg_q.shuffle_src[3] <= cfg_wdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	frgr_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.job_valid  (job_valid),
		.job        (job)
	);

	frgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_valid),
		.push_data  (job),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	frgr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.rsp        (rsp)
	);

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("Back end popped an empty job queue.");

	assert property (@(posedge clk) disable iff (!arst_n)
			(req.valid && req.ready) |-> !queue_full)
		else $error("Word accepted while the job queue was full.");

	assert property (@(posedge clk) disable iff (!arst_n)
			(queue_full && !pop) |=> queue_full)
		else $error("Job queue lost an entry without a pop.");

endmodule

`default_nettype wire

// ===== sim/tb_frame_geometric_remap_reader.sv =====
// Self-checking testbench that drives random pixel writes and reads under every transform mode.
`timescale 1ns / 100ps

module tb_frame_geometric_remap_reader;
	import frgr_pkg::*;

	typedef struct packed {
		logic               command;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
	} access_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	frgr_req_if req_ch ();
	frgr_rsp_if rsp_ch ();

	frame_geometric_remap_reader uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	access_t access_q[$];
	pixel_t  pixel_due_q[$];
	pixel_t  frame_copy[FRAME_SIDE * FRAME_SIDE];
	bit      planned_written[FRAME_SIDE * FRAME_SIDE];
	cfg_t    active_cfg;
	access_t offer;
	pixel_t  due;
	int      mismatch_count = 0;
	int      pixels_checked = 0;
	int      send_gap;
	int      recv_stall;
	logic    quiet_phase;
	logic    recv_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_frame_geometric_remap_reader failed");
		$finish;
	end

	function automatic int idle_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic cfg_t make_cfg(input logic [2:0] op, input logic [1:0] quad,
			input logic [2:0] factor, input logic [1:0] side,
			input logic [2:0] s0, s1, s2, s3);
		cfg_t c;
		c.op_mode = op;
		c.enlarge_quadrant = quad;
		c.shrink_factor = factor;
		c.mirror_side = side;
		c.shuffle_src[0] = s0;
		c.shuffle_src[1] = s1;
		c.shuffle_src[2] = s2;
		c.shuffle_src[3] = s3;
		return c;
	endfunction

	// Works out which stored pixel a read at (r, k) shows and what is done to it.
	function automatic bit locate_source(input cfg_t c, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] k, output logic [ADDR_W-1:0] src, output post_t post);
		int sr;
		int sc;
		int f;
		int lim;
		int qr;
		int qc;
		int s;
		logic [2:0] code;
		sr = r;
		sc = k;
		post = POST_PASS;
		case (c.op_mode)
			OP_INVERT: post = POST_INVERT;
			OP_ENLARGE: begin
				sr = (c.enlarge_quadrant[1] ? HALF_SIDE : 0) + r / 2;
				sc = (c.enlarge_quadrant[0] ? HALF_SIDE : 0) + k / 2;
			end
			OP_SHRINK: begin
				if (c.shrink_factor < SHRINK_MIN) f = SHRINK_MIN;
				else if (c.shrink_factor > SHRINK_MAX) f = SHRINK_MAX;
				else f = c.shrink_factor;
				lim = FRAME_SIDE / f;
				if (r < lim && k < lim) begin
					sr = r * f + f - 1;
					sc = k * f + f - 1;
				end else begin
					post = POST_WHITE;
				end
			end
			OP_MIRROR: begin
				case (c.mirror_side)
					MIR_RIGHT_ONTO_LEFT: if (k < HALF_SIDE) sc = FRAME_SIDE - 1 - k;
					MIR_LEFT_ONTO_RIGHT: if (k >= FRAME_SIDE - HALF_SIDE) sc = FRAME_SIDE - 1 - k;
					MIR_UPPER_ONTO_LOWER: if (r >= FRAME_SIDE - HALF_SIDE) sr = FRAME_SIDE - 1 - r;
					default: if (r < HALF_SIDE) sr = FRAME_SIDE - 1 - r;
				endcase
			end
			OP_SHUFFLE: begin
				if (r < 2 * HALF_SIDE && k < 2 * HALF_SIDE) begin
					qr = (r >= HALF_SIDE);
					qc = (k >= HALF_SIDE);
					code = c.shuffle_src[qr * 2 + qc];
					if (code != SHUF_KEEP && code <= SHUF_LAST) begin
						s = code - 1;
						sr = (s / 2) * HALF_SIDE + r - qr * HALF_SIDE;
						sc = (s % 2) * HALF_SIDE + k - qc * HALF_SIDE;
					end
				end
			end
			default: ;
		endcase
		src = {COORD_W'(sr % FRAME_SIDE), COORD_W'(sc % FRAME_SIDE)};
		return post != POST_WHITE;
	endfunction

	function automatic pixel_t remapped_pixel(input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] k);
		logic [ADDR_W-1:0] src;
		post_t post;
		pixel_t p;
		void'(locate_source(active_cfg, r, k, src, post));
		p = frame_copy[src];
		case (post)
			POST_INVERT: p = ~p;
			POST_WHITE: p = '1;
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return LAST_C;
			2: return HALF_C - 1'b1;
			3: return HALF_C;
			4: return SHRINK_LIM3 - 1'b1;
			5: return SHRINK_LIM3;
			6: return SHRINK_LIM4 - 1'b1;
			7: return SHRINK_LIM4;
			default: return COORD_W'($urandom_range(0, FRAME_SIDE - 1));
		endcase
	endfunction

	task automatic plan_write(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] k,
			input pixel_t p);
		access_t a;
		a.command = CMD_WRITE;
		a.row = r;
		a.col = k;
		{a.red, a.green, a.blue} = p;
		access_q.push_back(a);
		planned_written[{r, k}] = 1'b1;
	endtask

	// A read that shows a stored pixel that has never been written gets that pixel written first.
	task automatic plan_read(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] k);
		access_t a;
		logic [ADDR_W-1:0] src;
		post_t post;
		if (locate_source(active_cfg, r, k, src, post) &&
				(!planned_written[src] || $urandom_range(0, 3) == 0))
			plan_write(src[ADDR_W-1:COORD_W], src[COORD_W-1:0], pixel_t'(PIX_W'($urandom)));
		a.command = CMD_READ;
		a.row = r;
		a.col = k;
		{a.red, a.green, a.blue} = PIX_W'($urandom);
		access_q.push_back(a);
	endtask

	task automatic queue_phase(input int draws);
		repeat (draws) begin
			if ($urandom_range(0, 9) < 3)
				plan_write(pick_coord(), pick_coord(), pixel_t'(PIX_W'($urandom)));
			else
				plan_read(pick_coord(), pick_coord());
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_OP_MODE: active_cfg.op_mode = val;
			REG_ENLARGE_Q: active_cfg.enlarge_quadrant = val[1:0];
			REG_SHRINK: active_cfg.shrink_factor = val;
			REG_MIRROR_SIDE: active_cfg.mirror_side = val[1:0];
			default: active_cfg.shuffle_src[2'(idx - REG_SHUFFLE_Q0)] = val;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		@(posedge clk);
		write_reg(REG_OP_MODE, c.op_mode);
		write_reg(REG_ENLARGE_Q, {1'($urandom_range(0, 1)), c.enlarge_quadrant});
		write_reg(REG_SHRINK, c.shrink_factor);
		write_reg(REG_MIRROR_SIDE, {1'($urandom_range(0, 1)), c.mirror_side});
		for (int q = 0; q < 4; q++)
			write_reg(CFG_IDX_W'(REG_SHUFFLE_Q0 + q), c.shuffle_src[q]);
		cfg_we <= 1'b0;
	endtask

	// Writes leave no word behind, so a short pause follows the last read.
	task automatic drain();
		do @(negedge clk);
		while (access_q.size() != 0 || req_ch.valid || pixel_due_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= CMD_WRITE;
			req_ch.row <= '0;
			req_ch.col <= '0;
			req_ch.red_in <= '0;
			req_ch.green_in <= '0;
			req_ch.blue_in <= '0;
			send_gap <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (access_q.size() != 0) begin
				offer = access_q.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.command <= offer.command;
				req_ch.row <= offer.row;
				req_ch.col <= offer.col;
				req_ch.red_in <= offer.red;
				req_ch.green_in <= offer.green;
				req_ch.blue_in <= offer.blue;
				send_gap <= quiet_phase ? 0 : idle_length();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_stall <= 0;
		end else if (recv_hold) begin
			rsp_ch.ready <= 1'b0;
		end else if (recv_stall > 0) begin
			rsp_ch.ready <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			rsp_ch.ready <= 1'b0;
			recv_stall <= idle_length();
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// The receiver holds off long enough for the output buffer and job queue to fill.
	initial begin
		recv_hold = 1'b0;
		wait (pixels_checked >= 60 && access_q.size() >= 12);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (200) @(posedge clk);
		recv_hold <= 1'b0;
		wait (pixels_checked >= 250 && access_q.size() >= 12);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (120) @(posedge clk);
		recv_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.command == CMD_WRITE)
					frame_copy[{req_ch.row, req_ch.col}] =
						{req_ch.red_in, req_ch.green_in, req_ch.blue_in};
				else
					pixel_due_q.push_back(remapped_pixel(req_ch.row, req_ch.col));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pixel_due_q.size() == 0) begin
					report_mismatch("word returned with no read outstanding");
				end else begin
					due = pixel_due_q.pop_front();
					if (rsp_ch.red_out !== due.red)
						report_mismatch($sformatf("read %0d red %h, expected %h",
							pixels_checked, rsp_ch.red_out, due.red));
					if (rsp_ch.green_out !== due.green)
						report_mismatch($sformatf("read %0d green %h, expected %h",
							pixels_checked, rsp_ch.green_out, due.green));
					if (rsp_ch.blue_out !== due.blue)
						report_mismatch($sformatf("read %0d blue %h, expected %h",
							pixels_checked, rsp_ch.blue_out, due.blue));
					pixels_checked++;
				end
			end
		end
	end

	initial begin
		cfg_t plan[$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		quiet_phase = 1'b0;
		active_cfg = make_cfg(OP_INVERT, 2'd0, SHRINK_MIN, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Corners and the centre under the reset settings, one corner overwritten.
		plan_write('0, '0, 24'h000000);
		plan_write(LAST_C, LAST_C, 24'hFFFFFF);
		plan_write('0, LAST_C, 24'hA55AF0);
		plan_write(LAST_C, '0, 24'h5AA50F);
		plan_write(HALF_C - 1'b1, HALF_C, 24'h807F01);
		plan_read('0, '0);
		plan_read(LAST_C, LAST_C);
		plan_read('0, LAST_C);
		plan_read(LAST_C, '0);
		plan_read(HALF_C - 1'b1, HALF_C);
		plan_write('0, '0, 24'hFF00FF);
		plan_read('0, '0);
		drain();

		plan.push_back(make_cfg(OP_ENLARGE, 2'd0, SHRINK_MIN, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_ENLARGE, 2'd1, SHRINK_MID, MIR_LEFT_ONTO_RIGHT,
			3'd1, 3'd2, 3'd3, 3'd4));
		plan.push_back(make_cfg(OP_ENLARGE, 2'd2, SHRINK_MAX, MIR_UPPER_ONTO_LOWER,
			3'd4, 3'd3, 3'd2, 3'd1));
		plan.push_back(make_cfg(OP_ENLARGE, 2'd3, 3'd7, MIR_LOWER_ONTO_UPPER,
			3'd7, 3'd7, 3'd7, 3'd7));
		plan.push_back(make_cfg(OP_SHRINK, 2'd3, SHRINK_MIN, MIR_LOWER_ONTO_UPPER,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd0, SHRINK_MID, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd1, SHRINK_MAX, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd2, 3'd0, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd0, 3'd1, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd0, 3'd5, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHRINK, 2'd0, 3'd7, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_MIRROR, 2'd0, SHRINK_MIN, MIR_RIGHT_ONTO_LEFT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_MIRROR, 2'd0, SHRINK_MIN, MIR_LEFT_ONTO_RIGHT,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_MIRROR, 2'd0, SHRINK_MIN, MIR_UPPER_ONTO_LOWER,
			SHUF_KEEP, SHUF_KEEP, SHUF_KEEP, SHUF_KEEP));
		plan.push_back(make_cfg(OP_MIRROR, 2'd3, 3'd6, MIR_LOWER_ONTO_UPPER,
			3'd1, 3'd1, 3'd1, 3'd1));
		plan.push_back(make_cfg(OP_SHUFFLE, 2'd0, SHRINK_MIN, MIR_RIGHT_ONTO_LEFT,
			3'd1, 3'd2, 3'd3, 3'd4));
		plan.push_back(make_cfg(OP_SHUFFLE, 2'd1, SHRINK_MAX, MIR_UPPER_ONTO_LOWER,
			3'd4, 3'd3, 3'd2, 3'd1));
		plan.push_back(make_cfg(OP_SHUFFLE, 2'd2, SHRINK_MID, MIR_LEFT_ONTO_RIGHT,
			3'd2, 3'd2, 3'd4, SHUF_KEEP));
		plan.push_back(make_cfg(OP_SHUFFLE, 2'd3, 3'd7, MIR_LOWER_ONTO_UPPER,
			3'd5, 3'd6, 3'd7, SHUF_KEEP));
		plan.push_back(make_cfg(3'd5, 2'd0, SHRINK_MIN, MIR_RIGHT_ONTO_LEFT,
			3'd3, 3'd1, 3'd4, 3'd2));
		plan.push_back(make_cfg(3'd7, 2'd3, 3'd7, MIR_LOWER_ONTO_UPPER,
			3'd7, 3'd7, 3'd7, 3'd7));
		plan.push_back(make_cfg(OP_INVERT, 2'd3, 3'd7, MIR_LOWER_ONTO_UPPER,
			3'd4, 3'd4, 3'd4, 3'd4));
		repeat (5)
			plan.push_back(make_cfg(3'($urandom), 2'($urandom), 3'($urandom), 2'($urandom),
				3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom)));

		foreach (plan[i]) begin
			apply_cfg(plan[i]);
			quiet_phase <= ($urandom_range(0, 4) == 0);
			queue_phase(20);
			drain();
		end

		if (pixel_due_q.size() != 0)
			report_mismatch($sformatf("%0d reads never answered", pixel_due_q.size()));
		if (mismatch_count == 0)
			$display("tb_frame_geometric_remap_reader passed");
		else
			$display("tb_frame_geometric_remap_reader failed");
		$finish;
	end

endmodule
